// File: design/sip_dialog_state_table_top_assert.svh
// Assertion macros for the checker file of the dialog state table.
`ifndef SIP_DIALOG_STATE_TABLE_TOP_ASSERT_SVH
`define SIP_DIALOG_STATE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define SDST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define SDST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sdst_pkg.sv
// ----------------------------------------------------------------------------
// sdst_pkg
// Codes and controller/datapath interface types of the dialog state table.
// ----------------------------------------------------------------------------
package sdst_pkg;

    // Operation codes
    localparam logic [3:0] OP_TDEL    = 4'd0;
    localparam logic [3:0] OP_RPL1XX  = 4'd1;
    localparam logic [3:0] OP_RPL3XX  = 4'd2;
    localparam logic [3:0] OP_RPL2XX  = 4'd3;
    localparam logic [3:0] OP_ACK     = 4'd4;
    localparam logic [3:0] OP_BYE     = 4'd5;
    localparam logic [3:0] OP_PRACK   = 4'd6;
    localparam logic [3:0] OP_REQ     = 4'd7;
    localparam logic [3:0] OP_CREATE  = 4'd8;
    localparam logic [3:0] OP_RELEASE = 4'd9;
    localparam logic [3:0] OP_LOOKUP  = 4'd10;

    // Dialog states
    localparam logic [2:0] ST_UNCONF  = 3'd0;
    localparam logic [2:0] ST_EARLY   = 3'd1;
    localparam logic [2:0] ST_CONF_NA = 3'd2;
    localparam logic [2:0] ST_CONF    = 3'd3;
    localparam logic [2:0] ST_DELETED = 3'd4;

    // Result status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_BOGUS   = 3'd1;
    localparam logic [2:0] STAT_UNKNOWN = 3'd2;
    localparam logic [2:0] STAT_EMPTY   = 3'd3;
    localparam logic [2:0] STAT_BUSY    = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;   // write an empty entry at the sweep address
        logic capture;    // latch the item and read its record
        logic exec;       // update the record and register the result
    } sdst_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last; // sweep address is at the last entry
    } sdst_stat_t;

endpackage

// File: design/sdst_ctrl.sv
// ----------------------------------------------------------------------------
// sdst_ctrl
// Sequencer: clearing sweep after reset, then accept / execute per item.
// ----------------------------------------------------------------------------
module sdst_ctrl
    import sdst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  sdst_stat_t stat,
    output sdst_cmd_t  cmd,
    output logic       busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.clear_wr = 1'b0;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/sdst_datapath.sv
// ----------------------------------------------------------------------------
// sdst_datapath
// Record memory, item registers, transition logic and result registers.
// ----------------------------------------------------------------------------
module sdst_datapath
    import sdst_pkg::*;
#(
    parameter int SLOTS    = 1024,
    parameter int REF_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  sdst_cmd_t   cmd,
    output sdst_stat_t  stat,
    input  logic [3:0]  op,
    input  logic [9:0]  slot,
    input  logic [7:0]  count,
    output logic        done,
    output logic [2:0]  state_before,
    output logic [2:0]  state_after,
    output logic        caller_unref,
    output logic [2:0]  status,
    output logic [15:0] ref_count,
    output logic        freed
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int EXT_W = ((IDX_W > 10) ? IDX_W : 10) + 1;
    localparam int REC_W = REF_BITS + 5;           // valid, state, bye, refs
    localparam int SUM_W = ((REF_BITS > 9) ? REF_BITS : 9) + 1;
    localparam logic [SUM_W-1:0] REF_MAX = SUM_W'({REF_BITS{1'b1}});

    logic [REC_W-1:0] mem [SLOTS];

    logic [IDX_W-1:0] clr_cnt_reg;
    logic [3:0]       op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             inrange_reg;
    logic [7:0]       cnt_reg;
    logic [REC_W-1:0] rd_data_reg;

    logic             done_reg;
    logic [2:0]       state_before_reg;
    logic [2:0]       state_after_reg;
    logic             unref_reg;
    logic [2:0]       status_reg;
    logic [15:0]      ref_count_reg;
    logic             freed_reg;

    logic [EXT_W-1:0] slot_ext;
    logic [IDX_W-1:0] in_idx;

    logic                rd_valid;
    logic [2:0]          rd_state;
    logic                rd_bye;
    logic [REF_BITS-1:0] rd_refs;
    logic                valid;

    logic [SUM_W-1:0]    refs_ext;
    logic [SUM_W-1:0]    inc_sum;
    logic [SUM_W-1:0]    create_sum;
    logic [REF_BITS-1:0] refs_inc;
    logic [REF_BITS-1:0] refs_create;
    logic                rel_under;
    logic                tdel_under;

    logic                n_valid;
    logic [2:0]          n_state;
    logic                n_bye;
    logic [REF_BITS-1:0] n_refs;
    logic                wr_en;
    logic [2:0]          r_old;
    logic [2:0]          r_new;
    logic                r_unref;
    logic [2:0]          r_status;
    logic [REF_BITS-1:0] r_refs;
    logic                r_freed;
    logic [31:0]         r_refs32;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [REC_W-1:0] mem_wdata;

    assign slot_ext = EXT_W'(slot);
    assign in_idx   = slot_ext[IDX_W-1:0];

    assign stat.clear_last = (clr_cnt_reg == IDX_W'(SLOTS - 1));

    // Unpack the record read for the current item
    assign rd_valid = rd_data_reg[REC_W-1];
    assign rd_state = rd_data_reg[REC_W-2 -: 3];
    assign rd_bye   = rd_data_reg[REF_BITS];
    assign rd_refs  = rd_data_reg[REF_BITS-1:0];
    assign valid    = inrange_reg && rd_valid;

    // Saturating reference arithmetic
    assign refs_ext    = SUM_W'(rd_refs);
    assign inc_sum     = refs_ext + SUM_W'(1);
    assign create_sum  = SUM_W'(cnt_reg) + SUM_W'(1);
    assign refs_inc    = (inc_sum > REF_MAX) ? REF_BITS'(REF_MAX) : REF_BITS'(inc_sum);
    assign refs_create = (create_sum > REF_MAX) ? REF_BITS'(REF_MAX) : REF_BITS'(create_sum);
    assign rel_under   = (SUM_W'(cnt_reg) >= refs_ext);
    assign tdel_under  = (SUM_W'(1) >= refs_ext);

    always_comb
    begin
        n_valid  = rd_valid;
        n_state  = rd_state;
        n_bye    = rd_bye;
        n_refs   = rd_refs;
        wr_en    = 1'b0;
        r_old    = 3'd0;
        r_unref  = 1'b0;
        r_status = STAT_OK;
        r_freed  = 1'b0;
        r_new    = 3'd0;
        r_refs   = '0;
        if (op_reg == OP_CREATE)
        begin
            if (!inrange_reg)
            begin
                r_status = STAT_EMPTY;
            end
            else if (valid)
            begin
                r_status = STAT_BUSY;
                r_old    = rd_state;
                r_new    = rd_state;
                r_refs   = rd_refs;
            end
            else
            begin
                wr_en   = 1'b1;
                n_valid = 1'b1;
                n_state = ST_UNCONF;
                n_bye   = 1'b0;
                n_refs  = refs_create;
                r_new   = ST_UNCONF;
                r_refs  = refs_create;
            end
        end
        else if (!valid)
        begin
            r_status = (op_reg > OP_LOOKUP) ? STAT_UNKNOWN : STAT_EMPTY;
        end
        else
        begin
            wr_en = 1'b1;
            r_old = rd_state;
            case (op_reg)
                OP_TDEL:
                begin
                    if (rd_state == ST_UNCONF || rd_state == ST_EARLY)
                    begin
                        n_state = ST_DELETED;
                        r_unref = 1'b1;
                    end
                    if (tdel_under)
                    begin
                        n_refs  = '0;
                        n_valid = 1'b0;
                        r_freed = 1'b1;
                    end
                    else
                    begin
                        n_refs = rd_refs - REF_BITS'(1);
                    end
                end
                OP_RPL1XX:
                begin
                    if (rd_state == ST_UNCONF || rd_state == ST_EARLY)
                        n_state = ST_EARLY;
                    else
                        r_status = STAT_BOGUS;
                end
                OP_RPL3XX:
                begin
                    if (rd_state == ST_UNCONF || rd_state == ST_EARLY)
                    begin
                        n_state = ST_DELETED;
                        r_unref = 1'b1;
                    end
                    else
                    begin
                        r_status = STAT_BOGUS;
                    end
                end
                OP_RPL2XX:
                begin
                    if (rd_state == ST_DELETED)
                    begin
                        // Late 2xx revives a record deleted without a bye
                        if (rd_bye)
                        begin
                            r_status = STAT_BOGUS;
                        end
                        else
                        begin
                            n_refs  = refs_inc;
                            n_state = ST_CONF_NA;
                        end
                    end
                    else if (rd_state == ST_UNCONF || rd_state == ST_EARLY)
                    begin
                        n_state = ST_CONF_NA;
                    end
                    else if (rd_state != ST_CONF_NA && rd_state != ST_CONF)
                    begin
                        r_status = STAT_BOGUS;
                    end
                end
                OP_ACK:
                begin
                    if (rd_state == ST_CONF_NA)
                        n_state = ST_CONF;
                    else if (rd_state != ST_CONF)
                        r_status = STAT_BOGUS;
                end
                OP_BYE:
                begin
                    if (rd_state == ST_CONF_NA || rd_state == ST_CONF)
                    begin
                        n_bye   = 1'b1;
                        n_state = ST_DELETED;
                        r_unref = 1'b1;
                    end
                    else
                    begin
                        r_status = STAT_BOGUS;
                    end
                end
                OP_PRACK:
                begin
                    if (rd_state != ST_EARLY && rd_state != ST_CONF_NA)
                        r_status = STAT_BOGUS;
                end
                OP_REQ:
                begin
                    if (rd_state != ST_CONF_NA && rd_state != ST_CONF)
                        r_status = STAT_BOGUS;
                end
                OP_RELEASE:
                begin
                    if (rel_under)
                    begin
                        n_refs  = '0;
                        n_valid = 1'b0;
                        r_freed = 1'b1;
                    end
                    else
                    begin
                        n_refs = rd_refs - REF_BITS'(cnt_reg);
                    end
                end
                OP_LOOKUP:
                begin
                    if (rd_state == ST_DELETED)
                        r_status = STAT_BOGUS;
                    else
                        n_refs = refs_inc;
                end
                default:
                begin
                    r_status = STAT_UNKNOWN;
                end
            endcase
            r_new  = n_state;
            r_refs = n_refs;
        end
    end

    assign r_refs32 = 32'(r_refs);

    assign mem_we    = cmd.clear_wr || (cmd.exec && wr_en);
    assign mem_waddr = cmd.clear_wr ? clr_cnt_reg : idx_reg;
    assign mem_wdata = cmd.clear_wr ? '0 : {n_valid, n_state, n_bye, n_refs};

    // Record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.capture)
        begin
            rd_data_reg <= mem[in_idx];
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op;
            idx_reg     <= in_idx;
            inrange_reg <= (slot_ext < EXT_W'(SLOTS));
            cnt_reg     <= count;
        end
        if (cmd.exec)
        begin
            state_before_reg <= r_old;
            state_after_reg  <= r_new;
            unref_reg        <= r_unref;
            status_reg       <= r_status;
            ref_count_reg    <= (r_refs32 > 32'hFFFF) ? 16'hFFFF : r_refs32[15:0];
            freed_reg        <= r_freed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            done_reg <= cmd.exec;
        end
    end

    assign done         = done_reg;
    assign state_before = state_before_reg;
    assign state_after  = state_after_reg;
    assign caller_unref = unref_reg;
    assign status       = status_reg;
    assign ref_count    = ref_count_reg;
    assign freed        = freed_reg;

endmodule

// File: design/sip_dialog_state_table_top.sv
// ----------------------------------------------------------------------------
// sip_dialog_state_table_top
// Table of call-dialog records driven by create/lookup/release and events.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  item in  | start && !busy     | op, slot, count
//  result   | done (one cycle)   | state_before, state_after, caller_unref,
//           |                    | status, ref_count, freed
//
//  The transfer cycle of an item reads the record at its slot, the next
//  cycle updates and writes it back. The result shows in the cycle after
//  that with done high for that cycle; a new item may transfer then too.
//  After reset busy stays high while the sweep clears every valid bit.
//  The receiver cannot stall: each result is taken in its done cycle.
//
module sip_dialog_state_table_top
    import sdst_pkg::*;
#(
    parameter int SLOTS    = 1024,
    parameter int REF_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  op,
    input  logic [9:0]  slot,
    input  logic [7:0]  count,
    output logic        done,
    output logic [2:0]  state_before,
    output logic [2:0]  state_after,
    output logic        caller_unref,
    output logic [2:0]  status,
    output logic [15:0] ref_count,
    output logic        freed
);

    sdst_cmd_t  cmd;
    sdst_stat_t stat;

    // Sequencer: clear sweep, then accept and execute one item at a time
    sdst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Record memory, transition rules and result registers
    sdst_datapath #(
        .SLOTS    (SLOTS),
        .REF_BITS (REF_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .slot         (slot),
        .count        (count),
        .done         (done),
        .state_before (state_before),
        .state_after  (state_after),
        .caller_unref (caller_unref),
        .status       (status),
        .ref_count    (ref_count),
        .freed        (freed)
    );

endmodule

// File: design/sdst_checker.sv
// ----------------------------------------------------------------------------
// sdst_checker
// Port-level checks of the dialog state table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sip_dialog_state_table_top_assert.svh"

module sdst_checker
    import sdst_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  state_before,
    input logic [2:0]  state_after,
    input logic [2:0]  status,
    input logic [15:0] ref_count,
    input logic        freed
);

    `SDST_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
    `SDST_ASSERT_NXT(a_accept_done, start && !busy, ##1 done, "result missing two cycles after transfer")
    `SDST_ASSERT_IMP(a_done_idle, done, !busy, "result shown while busy")
    `SDST_ASSERT_IMP(a_freed_zero, done && freed, ref_count == 16'd0, "freed with nonzero count")
    `SDST_ASSERT_IMP(a_empty_zero, done && status == STAT_EMPTY, state_before == 3'd0 && state_after == 3'd0 && ref_count == 16'd0, "empty slot result not zero")

endmodule

bind sip_dialog_state_table_top sdst_checker u_sdst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .state_before (state_before),
    .state_after  (state_after),
    .status       (status),
    .ref_count    (ref_count),
    .freed        (freed)
);
